[rtl/dos_pkg.sv]
// Shared constants, types and helper functions for the drop-oldest sample queue.
`timescale 1ns / 1ps
`default_nettype none

package dos_pkg;

  localparam int MAX_CHUNKS        = 16;
  localparam int SAMPLES_PER_CHUNK = 480;
  localparam int STORE_DEPTH       = MAX_CHUNKS * SAMPLES_PER_CHUNK;
  localparam int ADDR_W            = $clog2(STORE_DEPTH);
  localparam int FILL_W            = $clog2(STORE_DEPTH + 1);
  localparam int CHUNK_W           = $clog2(MAX_CHUNKS + 1);
  localparam int SAMPLE_W          = 16;
  localparam int DROP_W            = 32;
  localparam int CFG_W             = 5;

  // Division of the fill level by the chunk size as a multiply by a rounded-up reciprocal.
  localparam int DEPTH_SHIFT = 22;
  localparam int DEPTH_MUL   = (1 << DEPTH_SHIFT) / SAMPLES_PER_CHUNK + 1;
  localparam int DEPTH_MUL_W = $clog2(DEPTH_MUL + 1);
  localparam int PROD_W      = FILL_W + DEPTH_MUL_W;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_PULL  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } dos_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } dos_state_t;

  typedef struct packed {
    dos_kind_t            kind;
    logic [SAMPLE_W-1:0]  sample;
    logic                 last;
  } dos_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic                 real_smp;
    logic                 ok;
    logic [CHUNK_W-1:0]   depth;
    logic [DROP_W-1:0]    drop;
  } dos_result_t;

  function automatic logic [CHUNK_W-1:0] depth_of(input logic [FILL_W-1:0] f);
    logic [PROD_W-1:0] p;
    p = PROD_W'(f) * PROD_W'(DEPTH_MUL);
    return p[DEPTH_SHIFT +: CHUNK_W];
  endfunction

  function automatic logic [FILL_W-1:0] cap_of(input logic [CFG_W-1:0] c);
    logic [CFG_W-1:0] cc;
    cc = c;
    if (c == '0) cc = CFG_W'(1);
    if (c > CFG_W'(MAX_CHUNKS)) cc = CFG_W'(MAX_CHUNKS);
    return FILL_W'(cc) * FILL_W'(SAMPLES_PER_CHUNK);
  endfunction

endpackage

`default_nettype wire

[rtl/dos_ram.sv]
// Single-port synchronous sample RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module dos_ram #(
  parameter int DEPTH  = 7680,
  parameter int ADDR_W = 13,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/dos_ctrl.sv]
// Sequencer and ring pointers of the sample queue around the sample RAM.
`timescale 1ns / 1ps
`default_nettype none

module dos_ctrl
  import dos_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire dos_item_t         item,
  input  wire logic              out_free,
  input  wire logic [FILL_W-1:0] cap,
  input  wire logic [FILL_W-1:0] cap_m1,
  output logic                   idle,
  output logic                   res_load,
  output dos_result_t            res
);

  dos_state_t state, state_next;
  dos_item_t  cur;

  logic [ADDR_W-1:0]   rp, rp_next;
  logic [ADDR_W-1:0]   wp, wp_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic                bo, bo_next;
  logic [DROP_W-1:0]   drop, drop_next;
  logic                real_smp, real_next;
  logic                ok, ok_next;

  logic                ram_en, ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic                ovf, bo_new;

  dos_ram #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cur.sample),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rp       <= '0;
      wp       <= '0;
      fill     <= '0;
      bo       <= 1'b0;
      drop     <= '0;
      real_smp <= 1'b0;
      ok       <= 1'b0;
    end else begin
      state    <= state_next;
      rp       <= rp_next;
      wp       <= wp_next;
      fill     <= fill_next;
      bo       <= bo_next;
      drop     <= drop_next;
      real_smp <= real_next;
      ok       <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= item;
    end
  end

  always_comb begin
    state_next = state;
    rp_next    = rp;
    wp_next    = wp;
    fill_next  = fill;
    bo_next    = bo;
    drop_next  = drop;
    real_next  = real_smp;
    ok_next    = ok;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = wp;
    res_load   = 1'b0;
    ovf        = fill >= cap;
    bo_new     = bo | ovf;
    idle       = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        real_next  = 1'b0;
        ok_next    = 1'b0;
        state_next = ST_DONE;
        case (cur.kind)
          KIND_PUSH: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = wp;
            wp_next  = (wp == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp + 1'b1;
            if (ovf) begin
              // Keep the cap-1 newest samples behind the write pointer, then add this one.
              rp_next   = (wp >= ADDR_W'(cap_m1)) ? wp - ADDR_W'(cap_m1)
                        : wp + (ADDR_W'(STORE_DEPTH) - ADDR_W'(cap_m1));
              fill_next = cap;
            end else begin
              fill_next = fill + 1'b1;
            end
            ok_next = ~bo_new;
            if (cur.last) begin
              drop_next = drop + DROP_W'(bo_new);
              bo_next   = 1'b0;
            end else begin
              bo_next = bo_new;
            end
          end
          KIND_PULL: begin
            if (fill != '0) begin
              ram_en    = 1'b1;
              ram_addr  = rp;
              rp_next   = (rp == ADDR_W'(STORE_DEPTH - 1)) ? '0 : rp + 1'b1;
              fill_next = fill - 1'b1;
              real_next = 1'b1;
            end
          end
          KIND_CLEAR: begin
            rp_next   = '0;
            wp_next   = '0;
            fill_next = '0;
          end
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.sample   = real_smp ? ram_rdata : '0;
    res.real_smp = real_smp;
    res.ok       = ok;
    res.depth    = depth_of(fill);
    res.drop     = drop;
  end

endmodule

`default_nettype wire

[rtl/drop_oldest_sample_fifo.sv]
// Top level of the drop-oldest audio sample queue: ports, capacity register and result register.
//
// Channel  Direction  Handshake               Content
// s_*      in         s_tvalid / s_tready     push, pull or clear item
// m_*      out        m_tvalid / m_tready     one result per item
// cfg_*    in         cfg_valid / cfg_ready   capacity in chunks
//
// Each item passes through accept, at most one sample RAM access and result load, in that order.
// A new item is taken while the previous result still waits in the output register;
// that item then holds before its result load until the output register is free.
// Reset clears the pointers, fill level, overflow mark and drop counter; the sample
// RAM is not cleared, since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module drop_oldest_sample_fifo
  import dos_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,   // [15:0] sample_in
  input  wire logic [1:0]       s_tuser,   // [1:0] kind
  input  wire logic             s_tlast,   // batch_last
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [55:0]           m_tdata,   // [15:0] sample_out, [16] push_ok,
                                           // [21:17] depth_chunks, [53:22] drop_total
  output logic                  m_tuser,   // sample_real
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data   // max_chunks
);

  logic [FILL_W-1:0] cap, cap_m1;
  logic              start, out_free, idle, res_load;
  dos_item_t         item;
  dos_result_t       res, out_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle;
  assign start     = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  assign item.kind   = dos_kind_t'(s_tuser);
  assign item.sample = s_tdata;
  assign item.last   = s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= FILL_W'(STORE_DEPTH);
      cap_m1 <= FILL_W'(STORE_DEPTH - 1);
    end else if (cfg_valid && cfg_ready) begin
      cap    <= cap_of(cfg_data);
      cap_m1 <= cap_of(cfg_data) - 1'b1;
    end
  end

  dos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .out_free (out_free),
    .cap      (cap),
    .cap_m1   (cap_m1),
    .idle     (idle),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.drop, out_res.depth, out_res.ok, out_res.sample};
  assign m_tuser = out_res.real_smp;

`ifndef SYNTHESIS
  // An accepted item keeps the input closed until its work is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready)
    else $error("input accepted while an item is still in flight");

  // The reported depth never exceeds the queue size in chunks.
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:17] <= CHUNK_W'(MAX_CHUNKS)))
    else $error("depth above the queue size");

  // Padding is always a zero sample.
  a_padding_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[15:0] == 16'd0))
    else $error("padding sample not zero");

  // A result is never both a pulled sample and a push answer.
  a_pull_or_push: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser && m_tdata[16]))
    else $error("result flagged as pull and push at once");

  // A result is only loaded into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result overwrote a waiting result");
`endif

endmodule

`default_nettype wire
